@@ sv/pfc_pkg.sv @@
// Shared types, constants and helper functions of the pixel format converter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package pfc_pkg;

    localparam int PIXEL_W = 32;
    localparam int CHAN_W  = 8;
    localparam int COUNT_W = 3;
    localparam int FMT_W   = 3;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam int LUMA_W  = 24;

    localparam logic [15:0] LUMA_R_WEIGHT = 16'd19661;
    localparam logic [15:0] LUMA_G_WEIGHT = 16'd38666;
    localparam logic [15:0] LUMA_B_WEIGHT = 16'd7209;

    typedef enum logic [FMT_W-1:0] {
        FMT_L8       = 3'd0,
        FMT_A8L8     = 3'd1,
        FMT_A1R5G5B5 = 3'd2,
        FMT_A4R4G4B4 = 3'd3,
        FMT_R8G8B8   = 3'd4,
        FMT_A8R8G8B8 = 3'd5
    } pfc_fmt_t;

    localparam logic REG_SOURCE_FORMAT = 1'b0;
    localparam logic REG_TARGET_FORMAT = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [CHAN_W-1:0] a;
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] l;
    } pfc_chan_t;

    function automatic logic [COUNT_W-1:0] pfc_fmt_bytes(input pfc_fmt_t fmt);
        logic [COUNT_W-1:0] count;
        unique case (fmt)
            FMT_L8:       count = 3'd1;
            FMT_A8L8:     count = 3'd2;
            FMT_A1R5G5B5: count = 3'd2;
            FMT_A4R4G4B4: count = 3'd2;
            FMT_R8G8B8:   count = 3'd3;
            FMT_A8R8G8B8: count = 3'd4;
            default:      count = 3'd1;
        endcase
        return count;
    endfunction

endpackage

`default_nettype wire

@@ sv/pfc_regs.sv @@
// APB-style configuration registers holding the source and target formats.
// Depends on pfc_pkg for the format type, register indexes and port widths.
`default_nettype none

module pfc_regs import pfc_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output pfc_fmt_t               source_format,
    output pfc_fmt_t               target_format
);

    pfc_fmt_t source_format_reg;
    pfc_fmt_t target_format_reg;
    logic     write_en;
    logic     reg_index;

    assign write_en  = psel && penable && pwrite && pready;
    assign reg_index = paddr[2];
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_format_reg <= FMT_L8;
            target_format_reg <= FMT_L8;
        end else if (write_en) begin
            unique case (reg_index)
                REG_SOURCE_FORMAT: source_format_reg <= pfc_fmt_t'(pwdata[FMT_W-1:0]);
                REG_TARGET_FORMAT: target_format_reg <= pfc_fmt_t'(pwdata[FMT_W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_index)
            REG_SOURCE_FORMAT: prdata = {{(DATA_W-FMT_W){1'b0}}, source_format_reg};
            REG_TARGET_FORMAT: prdata = {{(DATA_W-FMT_W){1'b0}}, target_format_reg};
            default:           prdata = '0;
        endcase
    end

    assign source_format = source_format_reg;
    assign target_format = target_format_reg;

endmodule

`default_nettype wire

@@ sv/pfc_unpack.sv @@
// Expands a source pixel into 8-bit alpha, color and luminance channels.
// Depends on pfc_pkg for the format type, channel struct and luma weights.
`default_nettype none

module pfc_unpack import pfc_pkg::*; (
    input  wire logic [PIXEL_W-1:0] pixel,
    input  wire pfc_fmt_t           fmt,
    output pfc_chan_t               chan
);

    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] a;
    logic [CHAN_W-1:0] l;
    logic              grey;
    logic              valid;
    logic [LUMA_W-1:0] luma_sum;

    always_comb begin
        r     = '0;
        g     = '0;
        b     = '0;
        a     = 8'hFF;
        l     = '0;
        grey  = 1'b0;
        valid = 1'b1;
        case (fmt)
            FMT_L8: begin
                l    = pixel[7:0];
                grey = 1'b1;
            end
            FMT_A8L8: begin
                l    = pixel[7:0];
                a    = pixel[15:8];
                grey = 1'b1;
            end
            FMT_A1R5G5B5: begin
                r = {pixel[14:10], 3'b000};
                g = {pixel[9:5], 3'b000};
                b = {pixel[4:0], 3'b000};
                a = {CHAN_W{pixel[15]}};
            end
            FMT_A4R4G4B4: begin
                b = {pixel[3:0], 4'h0};
                g = {pixel[7:4], 4'h0};
                r = {pixel[11:8], 4'h0};
                a = {pixel[15:12], 4'h0};
            end
            FMT_R8G8B8: begin
                b = pixel[7:0];
                g = pixel[15:8];
                r = pixel[23:16];
            end
            FMT_A8R8G8B8: begin
                b = pixel[7:0];
                g = pixel[15:8];
                r = pixel[23:16];
                a = pixel[31:24];
            end
            default: begin
                valid = 1'b0;
            end
        endcase
    end

    assign luma_sum = LUMA_W'(LUMA_R_WEIGHT) * LUMA_W'(r)
                    + LUMA_W'(LUMA_G_WEIGHT) * LUMA_W'(g)
                    + LUMA_W'(LUMA_B_WEIGHT) * LUMA_W'(b);

    always_comb begin
        chan.valid = valid;
        chan.a     = a;
        if (grey) begin
            chan.r = l;
            chan.g = l;
            chan.b = l;
            chan.l = l;
        end else begin
            chan.r = r;
            chan.g = g;
            chan.b = b;
            chan.l = luma_sum[LUMA_W-1:LUMA_W-CHAN_W];
        end
    end

endmodule

`default_nettype wire

@@ sv/pfc_pack.sv @@
// Packs 8-bit channels into the target pixel format by truncation.
// Depends on pfc_pkg for the format type, channel struct and byte counts.
`default_nettype none

module pfc_pack import pfc_pkg::*; (
    input  wire pfc_chan_t           chan,
    input  wire pfc_fmt_t            fmt,
    output logic [PIXEL_W-1:0]       pixel,
    output logic [COUNT_W-1:0]       byte_count
);

    always_comb begin
        pixel = '0;
        if (chan.valid) begin
            case (fmt)
                FMT_L8:       pixel = {24'h0, chan.l};
                FMT_A8L8:     pixel = {16'h0, chan.a, chan.l};
                FMT_A1R5G5B5: pixel = {16'h0, chan.a[7], chan.r[7:3], chan.g[7:3], chan.b[7:3]};
                FMT_A4R4G4B4: pixel = {16'h0, chan.a[7:4], chan.r[7:4], chan.g[7:4],
                                       chan.b[7:4]};
                FMT_R8G8B8:   pixel = {8'h0, chan.r, chan.g, chan.b};
                FMT_A8R8G8B8: pixel = {chan.a, chan.r, chan.g, chan.b};
                default:      pixel = '0;
            endcase
        end
    end

    assign byte_count = pfc_fmt_bytes(fmt);

endmodule

`default_nettype wire

@@ sv/pixel_format_converter_unit.sv @@
// Pixel format converter top level: input register, conversion logic, result register.
// Depends on pfc_pkg, pfc_regs, pfc_unpack and pfc_pack.
//
// Usage: pixels enter on the s_ channel (s_valid, s_ready, s_pixel_in) as little-endian
// bytes and leave on the m_ channel (m_valid, m_ready, m_pixel_out, m_byte_count).
// The source and target formats are set through the APB port: register 0 at address 0
// holds the source format, register 1 at address 4 the target format; both reset to L8.
// Change them only while no transaction is in flight.
// A transaction accepted on the s_ channel is captured in the input register, converted
// by the combinational unpack and pack logic and captured in the result register, which
// drives the m_ channel. One transaction per cycle is sustained while m_ready stays high;
// the conversion path between the input and result registers is combinational.
// When the receiver stalls, the result register holds its transaction and the input
// register takes one more; s_ready falls only when both are full.
// Reset (aresetn low, synchronous) empties both registers and restores the formats.
`default_nettype none

module pixel_format_converter_unit import pfc_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    output logic      [DATA_W-1:0]   prdata,
    output logic                     pready,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [PIXEL_W-1:0]  s_pixel_in,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic      [PIXEL_W-1:0]  m_pixel_out,
    output logic      [COUNT_W-1:0]  m_byte_count
);

    pfc_fmt_t           source_format;
    pfc_fmt_t           target_format;
    pfc_chan_t          chan;
    logic               in_valid_reg;
    logic [PIXEL_W-1:0] in_pixel_reg;
    logic               out_valid_reg;
    logic [PIXEL_W-1:0] out_pixel_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [PIXEL_W-1:0] out_pixel_next;
    logic [COUNT_W-1:0] out_count_next;
    logic               advance;

    pfc_regs u_regs (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .source_format (source_format),
        .target_format (target_format)
    );

    pfc_unpack u_unpack (
        .pixel (in_pixel_reg),
        .fmt   (source_format),
        .chan  (chan)
    );

    pfc_pack u_pack (
        .chan       (chan),
        .fmt        (target_format),
        .pixel      (out_pixel_next),
        .byte_count (out_count_next)
    );

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
        if (s_valid && s_ready) begin
            in_pixel_reg <= s_pixel_in;
        end
        if (advance && in_valid_reg) begin
            out_pixel_reg <= out_pixel_next;
            out_count_reg <= out_count_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_pixel_out  = out_pixel_reg;
    assign m_byte_count = out_count_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_pixel_reg))
        else $error("Held input transaction changed while the result register stalled.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("Input stalled although the pipeline had room.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_byte_count >= 3'd1 && m_byte_count <= 3'd4)
        else $error("Result byte count out of range.");

endmodule

`default_nettype wire
